@@ rtl/core/mffd_pkg.sv @@
`default_nettype none

package mffd_pkg;

   // payload widths
   localparam int BYTE_W      = 8;
   localparam int FIELD_ID_W  = 3;
   localparam int FIELD_VAL_W = 64;
   localparam int RUN_W       = 2;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_START_MARKER = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_MARKER   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LENGTH   = 2'd2;

   localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'hAA;
   localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'hFC;
   localparam logic [BYTE_W-1:0] MAX_LENGTH_RST   = 8'd100;

   // marker repeat count that opens or closes a frame
   localparam logic [RUN_W-1:0] RUN_DONE = 2'd3;

   // field ids
   localparam logic [FIELD_ID_W-1:0] FID_LONGITUDE = 3'd0;
   localparam logic [FIELD_ID_W-1:0] FID_LATITUDE  = 3'd1;
   localparam logic [FIELD_ID_W-1:0] FID_HEIGHT    = 3'd2;
   localparam logic [FIELD_ID_W-1:0] FID_PITCH     = 3'd3;
   localparam logic [FIELD_ID_W-1:0] FID_ROLL      = 3'd4;
   localparam logic [FIELD_ID_W-1:0] FID_HEADING   = 3'd5;
   localparam logic [FIELD_ID_W-1:0] FID_LAST      = FID_HEADING;

   typedef struct packed {
      logic                  hit;
      logic [FIELD_ID_W-1:0] id;
   } field_end_type;

   // field that completes when the byte count reaches count
   function automatic field_end_type field_at(input logic [BYTE_W-1:0] count);
      field_end_type r;
      r.hit = 1'b1;
      r.id  = FID_LONGITUDE;
      case (count)
         8'd8:    r.id = FID_LONGITUDE;
         8'd16:   r.id = FID_LATITUDE;
         8'd20:   r.id = FID_HEIGHT;
         8'd24:   r.id = FID_PITCH;
         8'd28:   r.id = FID_ROLL;
         8'd32:   r.id = FID_HEADING;
         default: r.hit = 1'b0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/mffd_req_if.sv @@
`default_nettype none

interface mffd_req_if;
   import mffd_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

@@ rtl/core/mffd_rsp_if.sv @@
`default_nettype none

interface mffd_rsp_if;
   import mffd_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   field_valid;
   logic [FIELD_ID_W-1:0]  field_id;
   logic [FIELD_VAL_W-1:0] field_value;
   logic                   frame_done;
   logic                   overflow;

   modport source (output valid, output field_valid, output field_id,
                   output field_value, output frame_done, output overflow,
                   input ready);
   modport sink   (input valid, input field_valid, input field_id,
                   input field_value, input frame_done, input overflow,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/core/marker_framed_field_deframer_top.sv @@
// Marker framed field deframer.
// req_chan carries one received byte per word. While hunting, three start
// markers in a row open a frame; inside a frame every byte is counted and
// packed little-endian into fields (two 8-byte fields, then four 4-byte
// fields). rsp_chan returns exactly one word per request word: field_valid,
// field_id and field_value when a field completes, frame_done when three end
// markers in a row close the frame, overflow when the count passes max_length.
// Result is registered; it appears on rsp_chan the cycle after its byte is taken.
// Throughput: one byte per cycle unless a held result stalls req_chan; frame
// state and result register update in the same cycle the byte is accepted.
// Stall: the result register holds while rsp_chan.ready is low; req_chan.ready
// is high whenever the result register is empty or being emptied.
// Reset (synchronous, active high): hunting, counters and accumulator cleared,
// start_marker 0xAA, end_marker 0xFC, max_length 100, no result pending.
// csr_*: plain write port, index 0 start_marker, 1 end_marker, 2 max_length;
// write only while no word is in flight.

`default_nettype none

module marker_framed_field_deframer_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   mffd_req_if.sink                             req_chan,
   mffd_rsp_if.source                           rsp_chan,
   input  wire logic                            csr_write,
   input  wire logic [mffd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [mffd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import mffd_pkg::*;

   // configuration registers
   logic [BYTE_W-1:0] start_marker_ff;
   logic [BYTE_W-1:0] end_marker_ff;
   logic [BYTE_W-1:0] max_length_ff;

   // frame state
   logic                   in_frame_ff,    in_frame_in;
   logic [RUN_W-1:0]       header_run_ff,  header_run_in;
   logic [RUN_W-1:0]       trailer_run_ff, trailer_run_in;
   logic [BYTE_W-1:0]      byte_count_ff,  byte_count_in;
   logic [FIELD_VAL_W-1:0] field_accum_ff, field_accum_in;

   // result register
   logic                   rsp_valid_ff,   rsp_valid_in;
   logic                   field_valid_ff, field_valid_in;
   logic [FIELD_ID_W-1:0]  field_id_ff,    field_id_in;
   logic [FIELD_VAL_W-1:0] field_value_ff, field_value_in;
   logic                   frame_done_ff,  frame_done_in;
   logic                   overflow_ff,    overflow_in;

   logic                   accept;
   logic [BYTE_W-1:0]      rx_byte;
   logic [2:0]             lane;
   logic [FIELD_VAL_W-1:0] merged;
   logic [BYTE_W-1:0]      count_next;
   logic [RUN_W-1:0]       header_inc;
   logic [RUN_W-1:0]       trailer_inc;
   field_end_type          fend;

   // handshake: take a byte when the result slot is free or draining
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign rx_byte        = req_chan.rx_byte;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= START_MARKER_RST;
         end_marker_ff   <= END_MARKER_RST;
         max_length_ff   <= MAX_LENGTH_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_START_MARKER: start_marker_ff <= csr_wdata;
            CSR_END_MARKER:   end_marker_ff   <= csr_wdata;
            CSR_MAX_LENGTH:   max_length_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // byte lane within the field being assembled
   always_comb begin
      lane   = byte_count_ff[2:0];
      merged = field_accum_ff;
      if (byte_count_ff[7:4] == 4'd0) begin
         lane   = byte_count_ff[2:0];
         merged = field_accum_ff | ({{(FIELD_VAL_W-BYTE_W){1'b0}}, rx_byte} << {lane, 3'b000});
      end else if (byte_count_ff[7:5] == 3'd0) begin
         lane   = {1'b0, byte_count_ff[1:0]};
         merged = field_accum_ff | ({{(FIELD_VAL_W-BYTE_W){1'b0}}, rx_byte} << {lane, 3'b000});
      end
   end

   assign count_next  = byte_count_ff + 8'd1;
   assign header_inc  = header_run_ff + 2'd1;
   assign trailer_inc = trailer_run_ff + 2'd1;
   assign fend        = field_at(count_next);

   // frame state update and result for the byte on req_chan
   always_comb begin
      in_frame_in    = in_frame_ff;
      header_run_in  = header_run_ff;
      trailer_run_in = trailer_run_ff;
      byte_count_in  = byte_count_ff;
      field_accum_in = field_accum_ff;
      field_valid_in = 1'b0;
      field_id_in    = FID_LONGITUDE;
      field_value_in = '0;
      frame_done_in  = 1'b0;
      overflow_in    = 1'b0;

      if (!in_frame_ff) begin
         // hunting for the start marker run
         if (rx_byte == start_marker_ff) begin
            header_run_in = header_inc;
            if (header_inc == RUN_DONE) begin
               in_frame_in   = 1'b1;
               header_run_in = '0;
            end
         end else begin
            header_run_in = '0;
         end
      end else begin
         byte_count_in  = count_next;
         field_accum_in = merged;
         if (fend.hit) begin
            field_valid_in = 1'b1;
            field_id_in    = fend.id;
            field_value_in = merged;
            field_accum_in = '0;
         end

         // abandon a frame that ran too long
         if (count_next > max_length_ff) begin
            byte_count_in  = '0;
            in_frame_in    = 1'b0;
            field_accum_in = '0;
            overflow_in    = 1'b1;
         end

         // end marker run
         if (rx_byte == end_marker_ff) begin
            trailer_run_in = trailer_inc;
            if (trailer_inc == RUN_DONE) begin
               trailer_run_in = '0;
               in_frame_in    = 1'b0;
               byte_count_in  = '0;
               field_accum_in = '0;
               frame_done_in  = 1'b1;
            end
         end else begin
            trailer_run_in = '0;
         end
      end
   end

   // result slot occupancy
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff    <= 1'b0;
         header_run_ff  <= '0;
         trailer_run_ff <= '0;
         byte_count_ff  <= '0;
         field_accum_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            in_frame_ff    <= in_frame_in;
            header_run_ff  <= header_run_in;
            trailer_run_ff <= trailer_run_in;
            byte_count_ff  <= byte_count_in;
            field_accum_ff <= field_accum_in;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         field_valid_ff <= field_valid_in;
         field_id_ff    <= field_id_in;
         field_value_ff <= field_value_in;
         frame_done_ff  <= frame_done_in;
         overflow_ff    <= overflow_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.field_valid = field_valid_ff;
   assign rsp_chan.field_id    = field_id_ff;
   assign rsp_chan.field_value = field_value_ff;
   assign rsp_chan.frame_done  = frame_done_ff;
   assign rsp_chan.overflow    = overflow_ff;

   // no field data on a word without a completed field
   a_idle_field_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !field_valid_ff) |-> (field_value_ff == '0 && field_id_ff == '0))
      else $error("field data on a word without a field");

   // field ids stay within the defined set
   a_field_id_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && field_valid_ff) |-> (field_id_ff <= FID_LAST))
      else $error("field id out of range");

   // a hunting block holds no partial field or byte count
   a_hunt_clean: assert property (@(posedge clock) disable iff (reset)
      !in_frame_ff |-> (byte_count_ff == '0 && field_accum_ff == '0))
      else $error("stale frame state while hunting");

   // result slot is empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("result pending after reset");

endmodule

`default_nettype wire
